// File: design/ssp_pkg.sv
// shared constants, types and helpers for the second shortest path engine
package ssp_pkg;

  localparam int MAX_NODES   = 4096;
  localparam int NODE_W      = 13;
  localparam int MAX_LINKS   = 32768;
  localparam int LINK_AW     = $clog2(MAX_LINKS);
  localparam int LINK_CW     = LINK_AW + 1;
  localparam int HEAP_DEPTH  = 32768;
  localparam int HEAP_AW     = $clog2(HEAP_DEPTH);
  localparam int HEAP_CW     = HEAP_AW + 1;
  localparam int WEIGHT_W    = 16;
  localparam int DIST_W      = 31;
  localparam int KEY_W       = DIST_W + NODE_W;
  localparam int LINK_DW     = LINK_CW + NODE_W + WEIGHT_W;
  localparam int PAIR_W      = 2 * DIST_W;

  localparam logic [DIST_W-1:0] INF_DIST = {DIST_W{1'b1}};

  localparam logic [1:0] KIND_ADD     = 2'd0;
  localparam logic [1:0] KIND_COMPUTE = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE,
    S_ADD_RA, S_ADD_WA, S_ADD_RB, S_ADD_WB,
    S_INIT, S_SEED,
    S_POP, S_POP_TOP, S_POP_LAST,
    S_SD_CHK, S_SD_RC, S_SD_RC2, S_SD_CMP, S_SD_END,
    S_U_CHK, S_U_RD, S_HEAD, S_LK, S_LK_RD, S_V_RD,
    S_PUSH, S_SU_CHK, S_SU_RD, S_SU_END,
    S_RES_RD, S_RES, S_OUT
  } state_t;

  // saturating path sum
  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                input logic [WEIGHT_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + (DIST_W+1)'(b);
    return (s > (DIST_W+1)'(INF_DIST)) ? INF_DIST : s[DIST_W-1:0];
  endfunction

endpackage

// File: design/ssp_ram.sv
// generic one write, one read port memory with registered read data
module ssp_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/second_shortest_path_engine.sv
// top level: edge store, heap and sequencer for the second shortest path search
//
// Input beats carry kind, end_a, end_b and weight. kind add stores an
// undirected edge as two links if both ends are in range and the store has
// room, kind clear empties the edge store by sweeping the list heads, kind
// compute runs the search from node 1 and produces one output beat with
// second_distance and status; other kinds are dropped. The node count
// register is written through cfg_wr_en / cfg_wr_data; the user must write
// it only while the block is idle; the block itself does not enforce it.
// A compute beat first sets up the distance table, then pops heap entries
// one at a time and walks the links of each popped node, pushing an entry
// when a link lowers its target's best or runner-up distance and the heap
// has room. One sequencer does all the work; each memory takes at most one
// read and one write a cycle. in_stall is high whenever the sequencer is
// busy. After reset the list heads are swept clear before the first beat
// is taken. A stalled result holds in the output register; a finished
// compute waits for that register to free before going idle.
module second_shortest_path_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_kind,
  input  logic [ssp_pkg::NODE_W-1:0]   in_end_a,
  input  logic [ssp_pkg::NODE_W-1:0]   in_end_b,
  input  logic [ssp_pkg::WEIGHT_W-1:0] in_weight,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ssp_pkg::DIST_W-1:0]   out_second_distance,
  output logic                         out_status,
  input  logic                         cfg_wr_en,
  input  logic [ssp_pkg::NODE_W-1:0]   cfg_wr_data
);
  import ssp_pkg::*;

  state_t state_r, state_nxt;

  logic [NODE_W-1:0]   node_count_r;
  logic [NODE_W-1:0]   n_eff;
  logic [NODE_W-1:0]   cnt_r;
  logic [LINK_CW-1:0]  link_count_r;
  logic                ovf_r;
  logic [HEAP_CW-1:0]  heap_size_r;
  logic                heap_over_r;
  logic [NODE_W-1:0]   a_r, b_r;
  logic [WEIGHT_W-1:0] w_r;
  logic [DIST_W-1:0]   cost_r, nd_r;
  logic [NODE_W-1:0]   u_r, v_r;
  logic [LINK_CW-1:0]  lk_r, next_r;
  logic [KEY_W-1:0]    key_r, ca_r;
  logic [HEAP_AW-1:0]  i_r, child_r, par_r;
  logic [DIST_W-1:0]   res_dist_r;
  logic                res_status_r;
  logic                out_valid_r;
  logic [DIST_W-1:0]   out_dist_r;
  logic                out_status_r;

  // memory ports
  logic                head_we;
  logic [NODE_W-1:0]   head_wa, head_ra;
  logic [LINK_CW-1:0]  head_wd, head_rd;
  logic                link_we;
  logic [LINK_AW-1:0]  link_wa, link_ra;
  logic [LINK_DW-1:0]  link_wd, link_rd;
  logic                dist_we;
  logic [NODE_W-1:0]   dist_wa, dist_ra;
  logic [PAIR_W-1:0]   dist_wd, dist_rd;
  logic                heap_we;
  logic [HEAP_AW-1:0]  heap_wa, heap_ra;
  logic [KEY_W-1:0]    heap_wd, heap_rd;

  // derived values
  logic                in_beat, out_free, add_ok, edge_full;
  logic [HEAP_CW-1:0]  size_m1;
  logic [HEAP_CW:0]    c_ext, c1_ext;
  logic [NODE_W-1:0]   lk_tgt;
  logic [WEIGHT_W-1:0] lk_cost;
  logic [LINK_CW-1:0]  lk_nxt;
  logic [DIST_W-1:0]   lk_nd, rd_best, rd_run;

  ssp_ram #(.DEPTH(MAX_NODES + 1), .WIDTH(LINK_CW)) u_head (
    .clk(clk), .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
    .rd_addr(head_ra), .rd_data(head_rd)
  );

  ssp_ram #(.DEPTH(MAX_LINKS), .WIDTH(LINK_DW)) u_link (
    .clk(clk), .wr_en(link_we), .wr_addr(link_wa), .wr_data(link_wd),
    .rd_addr(link_ra), .rd_data(link_rd)
  );

  ssp_ram #(.DEPTH(MAX_NODES + 1), .WIDTH(PAIR_W)) u_dist (
    .clk(clk), .wr_en(dist_we), .wr_addr(dist_wa), .wr_data(dist_wd),
    .rd_addr(dist_ra), .rd_data(dist_rd)
  );

  ssp_ram #(.DEPTH(HEAP_DEPTH), .WIDTH(KEY_W)) u_heap (
    .clk(clk), .wr_en(heap_we), .wr_addr(heap_wa), .wr_data(heap_wd),
    .rd_addr(heap_ra), .rd_data(heap_rd)
  );

  // effective node count and helpers
  always_comb begin
    if (node_count_r == '0) begin
      n_eff = NODE_W'(1);
    end else if (node_count_r > NODE_W'(MAX_NODES)) begin
      n_eff = NODE_W'(MAX_NODES);
    end else begin
      n_eff = node_count_r;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_beat   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign add_ok    = (in_end_a != '0) && (in_end_a <= NODE_W'(MAX_NODES)) &&
                     (in_end_b != '0) && (in_end_b <= NODE_W'(MAX_NODES));
  assign edge_full = ((LINK_CW+1)'(link_count_r) + (LINK_CW+1)'(2)) >
                     (LINK_CW+1)'(MAX_LINKS);
  assign size_m1   = heap_size_r - HEAP_CW'(1);
  assign c_ext     = {1'b0, i_r, 1'b1};
  assign c1_ext    = c_ext + (HEAP_CW+1)'(1);
  assign lk_nxt    = link_rd[LINK_DW-1 -: LINK_CW];
  assign lk_tgt    = link_rd[WEIGHT_W +: NODE_W];
  assign lk_cost   = link_rd[WEIGHT_W-1:0];
  assign lk_nd     = sat_add(cost_r, lk_cost);
  assign rd_best   = dist_rd[PAIR_W-1 -: DIST_W];
  assign rd_run    = dist_rd[DIST_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:      if (cnt_r == NODE_W'(MAX_NODES)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_beat) begin
          case (in_kind)
            KIND_ADD:     if (add_ok && !edge_full) state_nxt = S_ADD_RA;
            KIND_COMPUTE: state_nxt = S_INIT;
            KIND_CLEAR:   state_nxt = S_CLR;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD_RA:   state_nxt = S_ADD_WA;
      S_ADD_WA:   state_nxt = S_ADD_RB;
      S_ADD_RB:   state_nxt = S_ADD_WB;
      S_ADD_WB:   state_nxt = S_IDLE;
      S_INIT:     if (cnt_r == n_eff) state_nxt = S_SEED;
      S_SEED:     state_nxt = S_POP;
      S_POP:      state_nxt = (heap_size_r == '0) ? S_RES_RD : S_POP_TOP;
      S_POP_TOP:  state_nxt = (size_m1 == '0) ? S_U_CHK : S_POP_LAST;
      S_POP_LAST: state_nxt = S_SD_CHK;
      S_SD_CHK: begin
        state_nxt = (c_ext >= (HEAP_CW+1)'(heap_size_r)) ? S_SD_END : S_SD_RC;
      end
      S_SD_RC: begin
        state_nxt = (c1_ext < (HEAP_CW+1)'(heap_size_r)) ? S_SD_RC2 : S_SD_CMP;
      end
      S_SD_RC2:   state_nxt = S_SD_CMP;
      S_SD_CMP:   state_nxt = (ca_r >= key_r) ? S_SD_END : S_SD_CHK;
      S_SD_END:   state_nxt = S_U_CHK;
      S_U_CHK:    state_nxt = (u_r == '0 || u_r > n_eff) ? S_POP : S_U_RD;
      S_U_RD:     state_nxt = (cost_r > rd_run) ? S_POP : S_HEAD;
      S_HEAD:     state_nxt = S_LK;
      S_LK: begin
        state_nxt = (lk_r == '0 || lk_r > LINK_CW'(MAX_LINKS)) ? S_POP : S_LK_RD;
      end
      S_LK_RD:    state_nxt = (lk_tgt == '0 || lk_tgt > n_eff) ? S_LK : S_V_RD;
      S_V_RD: begin
        if (nd_r < rd_best || (nd_r > rd_best && nd_r < rd_run)) begin
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_LK;
        end
      end
      S_PUSH: begin
        state_nxt = (heap_size_r >= HEAP_CW'(HEAP_DEPTH)) ? S_LK : S_SU_CHK;
      end
      S_SU_CHK:   state_nxt = (i_r == '0) ? S_SU_END : S_SU_RD;
      S_SU_RD:    state_nxt = (heap_rd <= key_r) ? S_SU_END : S_SU_CHK;
      S_SU_END:   state_nxt = S_LK;
      S_RES_RD:   state_nxt = S_RES;
      S_RES:      state_nxt = S_OUT;
      S_OUT:      if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;
    link_we = 1'b0; link_wa = '0; link_wd = '0; link_ra = '0;
    dist_we = 1'b0; dist_wa = '0; dist_wd = '0; dist_ra = '0;
    heap_we = 1'b0; heap_wa = '0; heap_wd = '0; heap_ra = '0;
    case (state_r)
      S_CLR: begin
        head_we = 1'b1;
        head_wa = cnt_r;
      end
      S_ADD_RA: head_ra = a_r;
      S_ADD_WA: begin
        link_we = 1'b1;
        link_wa = link_count_r[LINK_AW-1:0];
        link_wd = {head_rd, b_r, w_r};
        head_we = 1'b1;
        head_wa = a_r;
        head_wd = link_count_r + LINK_CW'(1);
      end
      S_ADD_RB: head_ra = b_r;
      S_ADD_WB: begin
        link_we = 1'b1;
        link_wa = link_count_r[LINK_AW-1:0];
        link_wd = {head_rd, a_r, w_r};
        head_we = 1'b1;
        head_wa = b_r;
        head_wd = link_count_r + LINK_CW'(1);
      end
      S_INIT: begin
        dist_we = 1'b1;
        dist_wa = cnt_r;
        dist_wd = {INF_DIST, INF_DIST};
      end
      S_SEED: begin
        dist_we = 1'b1;
        dist_wa = NODE_W'(1);
        dist_wd = {DIST_W'(0), INF_DIST};
        heap_we = 1'b1;
        heap_wa = '0;
        heap_wd = {DIST_W'(0), NODE_W'(1)};
      end
      S_POP:      heap_ra = '0;
      S_POP_TOP:  heap_ra = size_m1[HEAP_AW-1:0];
      S_SD_CHK:   heap_ra = c_ext[HEAP_AW-1:0];
      S_SD_RC:    heap_ra = c1_ext[HEAP_AW-1:0];
      S_SD_CMP: begin
        if (ca_r < key_r) begin
          heap_we = 1'b1;
          heap_wa = i_r;
          heap_wd = ca_r;
        end
      end
      S_SD_END: begin
        heap_we = 1'b1;
        heap_wa = i_r;
        heap_wd = key_r;
      end
      S_U_CHK:    dist_ra = u_r;
      S_U_RD:     head_ra = u_r;
      S_LK:       link_ra = LINK_AW'(lk_r - LINK_CW'(1));
      S_LK_RD:    dist_ra = lk_tgt;
      S_V_RD: begin
        if (nd_r < rd_best) begin
          dist_we = 1'b1;
          dist_wa = v_r;
          dist_wd = {nd_r, rd_best};
        end else if (nd_r > rd_best && nd_r < rd_run) begin
          dist_we = 1'b1;
          dist_wa = v_r;
          dist_wd = {rd_best, nd_r};
        end
      end
      S_SU_CHK:   heap_ra = HEAP_AW'((i_r - HEAP_AW'(1)) >> 1);
      S_SU_RD: begin
        if (heap_rd > key_r) begin
          heap_we = 1'b1;
          heap_wa = i_r;
          heap_wd = heap_rd;
        end
      end
      S_SU_END: begin
        heap_we = 1'b1;
        heap_wa = i_r;
        heap_wd = key_r;
      end
      S_RES_RD:   dist_ra = n_eff;
      default: ;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      cnt_r        <= '0;
      link_count_r <= '0;
      ovf_r        <= 1'b0;
      heap_size_r  <= '0;
      heap_over_r  <= 1'b0;
      node_count_r <= NODE_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        node_count_r <= cfg_wr_data;
      end
      // output beat valid
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: cnt_r <= cnt_r + NODE_W'(1);
        S_IDLE: begin
          cnt_r <= '0;
          if (in_beat) begin
            case (in_kind)
              KIND_ADD: if (add_ok && edge_full) ovf_r <= 1'b1;
              KIND_CLEAR: begin
                link_count_r <= '0;
                ovf_r        <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_ADD_WA, S_ADD_WB: link_count_r <= link_count_r + LINK_CW'(1);
        S_INIT: cnt_r <= cnt_r + NODE_W'(1);
        S_SEED: begin
          heap_size_r <= HEAP_CW'(1);
          heap_over_r <= 1'b0;
        end
        S_POP_TOP: heap_size_r <= size_m1;
        S_PUSH: begin
          if (heap_size_r >= HEAP_CW'(HEAP_DEPTH)) begin
            heap_over_r <= 1'b1;
          end else begin
            heap_size_r <= heap_size_r + HEAP_CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        a_r <= in_end_a;
        b_r <= in_end_b;
        w_r <= in_weight;
      end
      S_POP_TOP: begin
        cost_r <= heap_rd[KEY_W-1 -: DIST_W];
        u_r    <= heap_rd[NODE_W-1:0];
        i_r    <= '0;
      end
      S_POP_LAST: key_r <= heap_rd;
      S_SD_CHK:   child_r <= c_ext[HEAP_AW-1:0];
      S_SD_RC:    ca_r <= heap_rd;
      S_SD_RC2: begin
        if (heap_rd < ca_r) begin
          ca_r    <= heap_rd;
          child_r <= child_r + HEAP_AW'(1);
        end
      end
      S_SD_CMP:   if (ca_r < key_r) i_r <= child_r;
      S_HEAD:     lk_r <= head_rd;
      S_LK_RD: begin
        v_r    <= lk_tgt;
        nd_r   <= lk_nd;
        next_r <= lk_nxt;
        if (lk_tgt == '0 || lk_tgt > n_eff) begin
          lk_r <= lk_nxt;
        end
      end
      S_V_RD: begin
        key_r <= {nd_r, v_r};
        if (!(nd_r < rd_best || (nd_r > rd_best && nd_r < rd_run))) begin
          lk_r <= next_r;
        end
      end
      S_PUSH: begin
        i_r <= heap_size_r[HEAP_AW-1:0];
        if (heap_size_r >= HEAP_CW'(HEAP_DEPTH)) begin
          lk_r <= next_r;
        end
      end
      S_SU_CHK:   par_r <= HEAP_AW'((i_r - HEAP_AW'(1)) >> 1);
      S_SU_RD:    if (heap_rd > key_r) i_r <= par_r;
      S_SU_END:   lk_r <= next_r;
      S_RES: begin
        res_dist_r   <= rd_run;
        res_status_r <= ovf_r || heap_over_r;
      end
      S_OUT: begin
        if (out_free) begin
          out_dist_r   <= res_dist_r;
          out_status_r <= res_status_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_second_distance = out_dist_r;
  assign out_status          = out_status_r;

endmodule

// File: tb/tb_second_shortest_path_engine.sv
// testbench for the second shortest path engine: directed and random beats vs a predictor
module tb_second_shortest_path_engine;
  import ssp_pkg::*;

  localparam int WAIT_IDLE = 4400;   // covers the clear sweep after the last result
  localparam int KEY_SHIFT = 17;
  localparam int unsigned NO_PATH = 32'(INF_DIST);
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_kind;
  logic [NODE_W-1:0]   in_end_a;
  logic [NODE_W-1:0]   in_end_b;
  logic [WEIGHT_W-1:0] in_weight;
  logic                out_valid;
  logic                out_stall;
  logic [DIST_W-1:0]   out_second_distance;
  logic                out_status;
  logic                cfg_wr_en;
  logic [NODE_W-1:0]   cfg_wr_data;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              status;
  } path_result_t;

  path_result_t pending_paths[$];
  int error_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  // predictor state
  int unsigned     head_of[0:MAX_NODES];
  int unsigned     next_of[0:MAX_LINKS-1];
  int unsigned     target_of[0:MAX_LINKS-1];
  int unsigned     cost_of[0:MAX_LINKS-1];
  int unsigned     links_used;
  int unsigned     best_of[0:MAX_NODES];
  int unsigned     runner_of[0:MAX_NODES];
  longint unsigned heap_keys[0:HEAP_DEPTH-1];
  int unsigned     heap_fill;
  bit              store_overflow;
  int unsigned     node_count_reg;

  second_shortest_path_engine DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_end_a(in_end_a), .in_end_b(in_end_b), .in_weight(in_weight),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_second_distance(out_second_distance), .out_status(out_status),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // clock
  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // edge store model
  task automatic clear_store();
    for (int i = 0; i <= MAX_NODES; i++) head_of[i] = 0;
    links_used = 0;
    store_overflow = 0;
  endtask

  task automatic add_link(int unsigned from, int unsigned to, int unsigned cost);
    target_of[links_used] = to;
    cost_of[links_used] = cost;
    next_of[links_used] = head_of[from];
    head_of[from] = links_used + 1;
    links_used++;
  endtask

  // min-heap of {distance, node} keys
  function automatic bit heap_insert(int unsigned dist_in, int unsigned node);
    longint unsigned key;
    int unsigned i, p;
    key = (longint'(dist_in) << KEY_SHIFT) | node;
    if (heap_fill >= HEAP_DEPTH) return 0;
    i = heap_fill++;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (heap_keys[p] <= key) break;
      heap_keys[i] = heap_keys[p];
      i = p;
    end
    heap_keys[i] = key;
    return 1;
  endfunction

  function automatic longint unsigned heap_take();
    longint unsigned top, last;
    int unsigned i, c;
    top = heap_keys[0];
    i = 0;
    heap_fill--;
    if (heap_fill == 0) return top;
    last = heap_keys[heap_fill];
    forever begin
      c = 2 * i + 1;
      if (c >= heap_fill) break;
      if (c + 1 < heap_fill && heap_keys[c + 1] < heap_keys[c]) c++;
      if (heap_keys[c] >= last) break;
      heap_keys[i] = heap_keys[c];
      i = c;
    end
    heap_keys[i] = last;
    return top;
  endfunction

  // second shortest distance from node 1 to the target node
  function automatic path_result_t second_shortest();
    path_result_t r;
    int unsigned n, u, v, lk, cost, nd;
    longint unsigned key;
    bit heap_over;
    heap_over = 0;
    n = node_count_reg;
    if (n == 0) n = 1;
    if (n > MAX_NODES) n = MAX_NODES;
    for (int i = 1; i <= n; i++) begin
      best_of[i] = NO_PATH;
      runner_of[i] = NO_PATH;
    end
    heap_fill = 0;
    best_of[1] = 0;
    if (!heap_insert(0, 1)) heap_over = 1;
    while (heap_fill > 0) begin
      key = heap_take();
      cost = 32'(key >> KEY_SHIFT);
      u = 32'(key & ((64'd1 << KEY_SHIFT) - 1));
      if (u == 0 || u > n || cost > runner_of[u]) continue;
      lk = head_of[u];
      while (lk != 0 && lk <= MAX_LINKS) begin
        v = target_of[lk - 1];
        nd = cost + cost_of[lk - 1];
        if (v != 0 && v <= n) begin
          if (nd > NO_PATH) nd = NO_PATH;
          if (nd < best_of[v]) begin
            runner_of[v] = best_of[v];
            best_of[v] = nd;
            if (!heap_insert(nd, v)) heap_over = 1;
          end else if (nd > best_of[v] && nd < runner_of[v]) begin
            runner_of[v] = nd;
            if (!heap_insert(nd, v)) heap_over = 1;
          end
        end
        lk = next_of[lk - 1];
      end
    end
    r.distance = DIST_W'(runner_of[n]);
    r.status = store_overflow | heap_over;
    return r;
  endfunction

  // apply one accepted beat to the model
  task automatic model_beat(logic [1:0] kind, int unsigned a, int unsigned b, int unsigned w);
    case (kind)
      KIND_ADD: begin
        if (a != 0 && a <= MAX_NODES && b != 0 && b <= MAX_NODES) begin
          if (links_used + 2 > MAX_LINKS) store_overflow = 1;
          else begin
            add_link(a, b, w);
            add_link(b, a, w);
          end
        end
      end
      KIND_COMPUTE: pending_paths = {pending_paths, second_shortest()};
      KIND_CLEAR: clear_store();
      default: ;
    endcase
  endtask

  // send one beat and wait for it to be taken
  task automatic send_beat(logic [1:0] kind, int unsigned a, int unsigned b, int unsigned w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_kind = kind;
    in_end_a = NODE_W'(a);
    in_end_b = NODE_W'(b);
    in_weight = WEIGHT_W'(w);
    do @(posedge clk); while (in_stall);
    model_beat(in_kind, 32'(in_end_a), 32'(in_end_b), 32'(in_weight));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // write node_count once the block has drained
  task automatic write_node_count(int unsigned value);
    wait (pending_paths.size() == 0);
    repeat (WAIT_IDLE) @(posedge clk);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = NODE_W'(value);
    node_count_reg = 32'(cfg_wr_data);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // receiver stall
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    path_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_paths.size() == 0) report_mismatch("unexpected beat", out_second_distance, 0);
      else begin
        want = pending_paths.pop_front();
        if (out_second_distance !== want.distance)
          report_mismatch("second_distance", out_second_distance, want.distance);
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
      end
    end
  end

  // directed special cases
  task automatic test_directed();
    send_beat(KIND_COMPUTE, 0, 0, 0);
    send_beat(KIND_ADD, 1, 1, 5);
    send_beat(KIND_COMPUTE, 0, 0, 0);
    write_node_count(4);
    send_beat(KIND_ADD, 1, 2, 0);
    send_beat(KIND_ADD, 2, 4, 16'hFFFF);
    send_beat(KIND_ADD, 1, 3, 7);
    send_beat(KIND_ADD, 3, 4, 7);
    send_beat(KIND_ADD, 4, 3, 7);
    send_beat(KIND_ADD, 4, 9, 1);
    send_beat(KIND_ADD, 0, 4, 1);
    send_beat(KIND_ADD, 8191, 4, 1);
    send_beat(KIND_ADD, 4097, 2, 1);
    send_beat(KIND_UNUSED, 1, 4, 1);
    send_beat(KIND_COMPUTE, 0, 0, 0);
    send_beat(KIND_CLEAR, 0, 0, 0);
    send_beat(KIND_COMPUTE, 0, 0, 0);
    write_node_count(0);
    send_beat(KIND_ADD, 1, 1, 3);
    send_beat(KIND_COMPUTE, 8191, 8191, 16'hFFFF);
    write_node_count(8191);
    send_beat(KIND_ADD, 1, 4096, 16'hFFFF);
    send_beat(KIND_ADD, 4096, 4096, 1);
    send_beat(KIND_COMPUTE, 0, 0, 0);
    write_node_count(4096);
    send_beat(KIND_COMPUTE, 0, 0, 0);
    send_beat(KIND_CLEAR, 0, 0, 0);
  endtask

  // random graphs with computes, plus noise
  task automatic test_random_graphs(int beats);
    int sent, n, edges, span;
    sent = 0;
    while (sent < beats) begin
      n = ($urandom_range(19) == 0) ? $urandom_range(8191) : $urandom_range(2, 10);
      write_node_count(n);
      for (int g = 0; g < 6 && sent < beats; g++) begin
        send_beat(KIND_CLEAR, $urandom_range(8191), $urandom_range(8191), $urandom);
        edges = $urandom_range(1, 12);
        span = (n < 2 || n > 12) ? 12 : n + 1;
        for (int e = 0; e < edges; e++) begin
          if ($urandom_range(9) == 0)
            send_beat(2'($urandom_range(3)), $urandom_range(8191), $urandom_range(8191),
                      $urandom);
          else
            send_beat(KIND_ADD, $urandom_range(1, span), $urandom_range(1, span),
                      $urandom_range(1) ? $urandom_range(20) : $urandom_range(65535));
          sent++;
        end
        send_beat(KIND_COMPUTE, $urandom_range(8191), $urandom_range(8191), $urandom);
        sent += 2;
      end
    end
  endtask

  // main sequence
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_ADD;
    in_end_a = '0;
    in_end_b = '0;
    in_weight = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    clear_store();
    node_count_reg = 1;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    send_idle_pct = 0;  stall_pct = 0;  test_random_graphs(320);
    send_idle_pct = 65; stall_pct = 0;  test_random_graphs(310);
    send_idle_pct = 0;  stall_pct = 65; test_random_graphs(310);
    send_idle_pct = 17; stall_pct = 17; test_random_graphs(310);
    wait (pending_paths.size() == 0);
    repeat (WAIT_IDLE) @(posedge clk);
    if (error_count == 0 && pending_paths.size() == 0)
      $display("tb_second_shortest_path_engine: clean");
    else
      $display("tb_second_shortest_path_engine: errors");
    $finish;
  end

  // run limit
  initial begin
    #(4 * 6000000);
    $display("tb_second_shortest_path_engine: errors");
    $finish;
  end

endmodule
